// File: design/kwtok_pkg.sv
// kwtok_pkg: types, codes and character constants for the keyword/identifier tokenizer
// no dependencies; imported by keyword_identifier_tokenizer and tb_top

package kwtok_pkg;

    // token kinds
    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_SYMBOL  = 3'd1;
    localparam logic [2:0] KIND_IDENT   = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    // keyword codes
    localparam logic [2:0] KW_CODE_FUNCTION = 3'd0;
    localparam logic [2:0] KW_CODE_RETURN   = 3'd1;

    // symbol codes
    localparam logic [2:0] SYM_LBRACE = 3'd0;
    localparam logic [2:0] SYM_RBRACE = 3'd1;
    localparam logic [2:0] SYM_LPAREN = 3'd2;
    localparam logic [2:0] SYM_RPAREN = 3'd3;
    localparam logic [2:0] SYM_SEMI   = 3'd4;
    localparam logic [2:0] SYM_PLUS   = 3'd5;
    localparam logic [2:0] CODE_NONE  = 3'd0;

    // keyword matcher state
    localparam logic [1:0] KW_NONE     = 2'd0;
    localparam logic [1:0] KW_FUNCTION = 2'd1;
    localparam logic [1:0] KW_RETURN   = 2'd2;

    // keyword text, first character in the top byte
    localparam logic [63:0] KW_TEXT_FUNCTION = "function";
    localparam logic [63:0] KW_TEXT_RETURN   = {"return", 16'h0000};
    localparam logic [3:0]  KW_LEN_FUNCTION  = 4'd8;
    localparam logic [3:0]  KW_LEN_RETURN    = 4'd6;

    // characters
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_R       = 8'h72;

    // one result item
    typedef struct packed {
        logic        last;
        logic [15:0] length;
        logic [31:0] index;
        logic [15:0] col;
        logic [15:0] line;
        logic [2:0]  code;
        logic [2:0]  kind;
    } tok_res_t;

    // keyword character at a given position (k: 0 function, 1 return)
    function automatic logic [7:0] kw_char(input logic k, input logic [2:0] pos);
        logic [63:0] txt;
        txt = k ? KW_TEXT_RETURN : KW_TEXT_FUNCTION;
        return txt[{~pos, 3'b000} +: 8];
    endfunction

    function automatic logic [3:0] kw_len(input logic k);
        return k ? KW_LEN_RETURN : KW_LEN_FUNCTION;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word_tail(input logic [7:0] c);
        return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_DOLLAR);
    endfunction

endpackage

// File: design/keyword_identifier_tokenizer.sv
// keyword_identifier_tokenizer: streaming lexer, one source byte per item, up to three tokens out
// depends on kwtok_pkg (codes, result struct, character tests)
//
//   channel | signals                            | contents
//   s_*     | tvalid tready tdata[7:0] tlast     | source byte, tlast = final byte of source
//   m_*     | tvalid tready tdata[87:0] tlast    | token, tlast = last token of that byte
//
// one byte is taken per cycle while s_tready is high; its tokens are computed in the same cycle and held in a
// three-entry result register that drains one token per cycle on the master side while m_tready is high.
// a byte giving at most one token sustains one byte per clock while m_tready is high; a byte giving
// more tokens holds the slave side while the result register drains.
// rst_n clears the lexer state and empties the result register; no clearing pass.
// m_tready low stalls the result register; s_tready is high only while the result
// register is empty or its single held token leaves in that cycle.

module keyword_identifier_tokenizer
    import kwtok_pkg::*;
#(
    parameter int LINE_BITS  = 16,
    parameter int COL_BITS   = 16,
    parameter int INDEX_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // token_kind[2:0], token_code[5:3], start_line[21:6],
                                   // start_col[37:22], start_index[69:38],
                                   // token_length[85:70], zero pad[87:86]
    output logic        m_tlast    // last_of_run
);

    localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;
    localparam int CW = (COL_BITS > 16) ? COL_BITS : 16;
    localparam int IW = (INDEX_BITS > 32) ? INDEX_BITS : 32;

    // counter values to output field widths
    function automatic logic [15:0] line_out(input logic [LINE_BITS-1:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        return w[15:0];
    endfunction

    function automatic logic [15:0] col_out(input logic [COL_BITS-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        return w[15:0];
    endfunction

    function automatic logic [31:0] index_out(input logic [INDEX_BITS-1:0] v);
        logic [IW-1:0] w;
        w = IW'(v);
        return w[31:0];
    endfunction

    function automatic tok_res_t make_res(input logic [2:0] kind, input logic [2:0] code,
                                          input logic [15:0] line, input logic [15:0] col,
                                          input logic [31:0] idx, input logic [15:0] len);
        tok_res_t r;
        r.last   = 1'b0;
        r.length = len;
        r.index  = idx;
        r.col    = col;
        r.line   = line;
        r.code   = code;
        r.kind   = kind;
        return r;
    endfunction

    // lexer state
    logic                  in_word_reg, in_word_next;
    logic [1:0]            kw_live_reg, kw_live_next;
    logic [15:0]           word_len_reg, word_len_next;
    logic [LINE_BITS-1:0]  cur_line_reg, cur_line_next;
    logic [COL_BITS-1:0]   cur_col_reg, cur_col_next;
    logic [INDEX_BITS-1:0] cur_index_reg, cur_index_next;
    logic [LINE_BITS-1:0]  word_line_reg, word_line_next;
    logic [COL_BITS-1:0]   word_col_reg, word_col_next;
    logic [INDEX_BITS-1:0] word_index_reg, word_index_next;
    logic                  halted_reg, halted_next;

    // result register
    tok_res_t   slot_reg [3];
    logic [1:0] cnt_reg;

    tok_res_t   res [3];
    logic [1:0] res_cnt;

    logic [7:0] c;
    logic       eos;
    logic       accept;
    logic       pop;

    assign c        = s_tdata;
    assign eos      = s_tlast;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    assign m_tdata = {2'b00, slot_reg[0].length, slot_reg[0].index, slot_reg[0].col,
                      slot_reg[0].line, slot_reg[0].code, slot_reg[0].kind};
    assign m_tlast = slot_reg[0].last;

    // per-byte lexing: next state and up to three tokens
    always_comb
    begin
        logic        adv;
        logic        k;
        logic [15:0] pos;
        logic        sym_hit;
        logic [2:0]  sym_code;

        in_word_next    = in_word_reg;
        kw_live_next    = kw_live_reg;
        word_len_next   = word_len_reg;
        cur_line_next   = cur_line_reg;
        cur_col_next    = cur_col_reg;
        cur_index_next  = cur_index_reg;
        word_line_next  = word_line_reg;
        word_col_next   = word_col_reg;
        word_index_next = word_index_reg;
        halted_next     = halted_reg;
        res[0]          = '0;
        res[1]          = '0;
        res[2]          = '0;
        res_cnt         = 2'd0;
        adv             = 1'b0;
        k               = kw_live_reg[1];
        pos             = word_len_reg;

        // symbol lookup
        sym_hit  = 1'b1;
        sym_code = CODE_NONE;
        case (c)
            CH_LBRACE: sym_code = SYM_LBRACE;
            CH_RBRACE: sym_code = SYM_RBRACE;
            CH_LPAREN: sym_code = SYM_LPAREN;
            CH_RPAREN: sym_code = SYM_RPAREN;
            CH_SEMI:   sym_code = SYM_SEMI;
            CH_PLUS:   sym_code = SYM_PLUS;
            default:   sym_hit  = 1'b0;
        endcase

        if (!halted_reg)
        begin
            if (in_word_reg && is_word_tail(c))
            begin
                // word continues, keyword matcher checks the next character
                adv           = 1'b1;
                word_len_next = (&word_len_reg) ? word_len_reg : word_len_reg + 16'd1;
                if ((kw_live_reg == KW_FUNCTION) || (kw_live_reg == KW_RETURN))
                begin
                    if ((pos >= 16'(kw_len(k))) || (kw_char(k, pos[2:0]) != c))
                    begin
                        kw_live_next = KW_NONE;
                    end
                    else if (pos + 16'd1 == 16'(kw_len(k)))
                    begin
                        res[res_cnt] = make_res(KIND_KEYWORD,
                                                k ? KW_CODE_RETURN : KW_CODE_FUNCTION,
                                                line_out(word_line_reg),
                                                col_out(word_col_reg),
                                                index_out(word_index_reg),
                                                16'(kw_len(k)));
                        res_cnt       = res_cnt + 2'd1;
                        in_word_next  = 1'b0;
                        kw_live_next  = KW_NONE;
                        word_len_next = 16'd0;
                    end
                end
                else
                begin
                    kw_live_next = KW_NONE;
                end
            end
            else
            begin
                // token start: flush a pending identifier first
                if (in_word_reg)
                begin
                    res[res_cnt] = make_res(KIND_IDENT, CODE_NONE, line_out(word_line_reg),
                                            col_out(word_col_reg),
                                            index_out(word_index_reg), word_len_reg);
                    res_cnt      = res_cnt + 2'd1;
                end
                in_word_next  = 1'b0;
                kw_live_next  = KW_NONE;
                word_len_next = 16'd0;

                if (is_letter(c))
                begin
                    in_word_next    = 1'b1;
                    word_len_next   = 16'd1;
                    word_line_next  = cur_line_reg;
                    word_col_next   = cur_col_reg;
                    word_index_next = cur_index_reg;
                    kw_live_next    = (c == CH_F) ? KW_FUNCTION :
                                      (c == CH_R) ? KW_RETURN : KW_NONE;
                    adv             = 1'b1;
                end
                else if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL))
                begin
                    adv = 1'b1;
                end
                else if (sym_hit)
                begin
                    res[res_cnt] = make_res(KIND_SYMBOL, sym_code, line_out(cur_line_reg),
                                            col_out(cur_col_reg), index_out(cur_index_reg),
                                            16'd1);
                    res_cnt      = res_cnt + 2'd1;
                    adv          = 1'b1;
                end
                else
                begin
                    res[res_cnt] = make_res(KIND_ERROR, CODE_NONE, line_out(cur_line_reg),
                                            col_out(cur_col_reg), index_out(cur_index_reg),
                                            16'd0);
                    res_cnt      = res_cnt + 2'd1;
                    halted_next  = 1'b1;
                end
            end
        end

        // position advance with saturation
        if (adv)
        begin
            if (c == CH_NL)
            begin
                cur_line_next = (&cur_line_reg) ? cur_line_reg
                                                : cur_line_reg + LINE_BITS'(1);
                cur_col_next  = '0;
            end
            else
            begin
                cur_col_next = (&cur_col_reg) ? cur_col_reg : cur_col_reg + COL_BITS'(1);
            end
            cur_index_next = (&cur_index_reg) ? cur_index_reg
                                              : cur_index_reg + INDEX_BITS'(1);
        end

        // final byte: flush, end marker, back to reset state
        if (eos)
        begin
            if (!halted_next && in_word_next)
            begin
                res[res_cnt] = make_res(KIND_IDENT, CODE_NONE, line_out(word_line_next),
                                        col_out(word_col_next), index_out(word_index_next),
                                        word_len_next);
                res_cnt      = res_cnt + 2'd1;
            end
            res[res_cnt] = make_res(KIND_END, CODE_NONE, line_out(cur_line_next),
                                    col_out(cur_col_next), index_out(cur_index_next), 16'd0);
            res_cnt      = res_cnt + 2'd1;

            in_word_next    = 1'b0;
            kw_live_next    = KW_NONE;
            word_len_next   = 16'd0;
            cur_line_next   = '0;
            cur_col_next    = '0;
            cur_index_next  = '0;
            word_line_next  = '0;
            word_col_next   = '0;
            word_index_next = '0;
            halted_next     = 1'b0;
        end

        // mark the last token of this byte
        if (res_cnt != 2'd0)
        begin
            res[res_cnt - 2'd1].last = 1'b1;
        end
    end

    // lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg    <= 1'b0;
            kw_live_reg    <= KW_NONE;
            word_len_reg   <= 16'd0;
            cur_line_reg   <= '0;
            cur_col_reg    <= '0;
            cur_index_reg  <= '0;
            word_line_reg  <= '0;
            word_col_reg   <= '0;
            word_index_reg <= '0;
            halted_reg     <= 1'b0;
        end
        else if (accept)
        begin
            in_word_reg    <= in_word_next;
            kw_live_reg    <= kw_live_next;
            word_len_reg   <= word_len_next;
            cur_line_reg   <= cur_line_next;
            cur_col_reg    <= cur_col_next;
            cur_index_reg  <= cur_index_next;
            word_line_reg  <= word_line_next;
            word_col_reg   <= word_col_next;
            word_index_reg <= word_index_next;
            halted_reg     <= halted_next;
        end
    end

    // result register fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            cnt_reg <= res_cnt;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // result register payload: load on accept, shift down on each pop
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[0] <= res[0];
            slot_reg[1] <= res[1];
            slot_reg[2] <= res[2];
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    // an error clears any pending word before halting
    a_halt_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !in_word_reg)
        else $error("halted with a pending word");

    // keyword matching only runs inside a word
    a_kw_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        (kw_live_reg != KW_NONE) |-> in_word_reg)
        else $error("keyword match active outside a word");

    // only the final held token of a byte carries the run marker
    a_last_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > 2'd1) |-> !slot_reg[0].last)
        else $error("run marker on a token that is not the last one");

    // the final held token always closes its run
    a_final_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> slot_reg[0].last)
        else $error("last held token lacks the run marker");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking stream testbench for keyword_identifier_tokenizer
// depends on kwtok_pkg and the dut; predicts tokens per accepted byte and checks them in order

module tb_top;
    import kwtok_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 20;
    localparam int RAND_BYTES  = 370;

    // token predictor and store of tokens still due from the dut
    class token_ledger;
        tok_res_t   due[$];
        tok_res_t   fresh[$];
        int         errors;
        string      kw_word[2];
        logic       in_ident;
        logic [1:0] kw_track;
        logic [15:0] ident_len;
        logic [15:0] line_pos;
        logic [15:0] col_pos;
        logic [31:0] byte_pos;
        logic [15:0] ident_line;
        logic [15:0] ident_col;
        logic [31:0] ident_pos;
        logic       stuck;

        function new();
            kw_word[0] = "function";
            kw_word[1] = "return";
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            in_ident   = 1'b0;
            kw_track   = KW_NONE;
            ident_len  = '0;
            line_pos   = '0;
            col_pos    = '0;
            byte_pos   = '0;
            ident_line = '0;
            ident_col  = '0;
            ident_pos  = '0;
            stuck      = 1'b0;
        endfunction

        // append one token to those of the current byte
        function void note_fresh(tok_res_t t);
            fresh.insert(fresh.size(), t);
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit ident_tail(logic [7:0] c);
            return alpha(c) || (c >= "0" && c <= "9") || c == CH_DOLLAR;
        endfunction

        function tok_res_t make_tok(logic [2:0] kind, logic [2:0] code, logic [15:0] ln,
                                    logic [15:0] cl, logic [31:0] ix, logic [15:0] len);
            tok_res_t t;
            t.kind   = kind;
            t.code   = code;
            t.line   = ln;
            t.col    = cl;
            t.index  = ix;
            t.length = len;
            t.last   = 1'b0;
            return t;
        endfunction

        // move the position past one consumed byte, all counters saturate
        function void step(logic [7:0] c);
            if (c == CH_NL) begin
                if (line_pos != '1) line_pos++;
                col_pos = '0;
            end else if (col_pos != '1) begin
                col_pos++;
            end
            if (byte_pos != '1) byte_pos++;
        endfunction

        function void flush_ident();
            if (in_ident)
                note_fresh(make_tok(KIND_IDENT, CODE_NONE, ident_line, ident_col,
                                    ident_pos, ident_len));
            in_ident  = 1'b0;
            kw_track  = KW_NONE;
            ident_len = '0;
        endfunction

        // one accepted source byte: work out the tokens it gives
        function void take_byte(logic [7:0] c, logic eos);
            int unsigned at;
            int         k;
            logic [2:0] scode;
            bit         is_sym;
            fresh.delete();
            if (!stuck) begin
                if (in_ident && ident_tail(c)) begin
                    at = ident_len;
                    if (ident_len != 16'hFFFF) ident_len++;
                    if (kw_track != KW_NONE) begin
                        k = (kw_track == KW_RETURN) ? 1 : 0;
                        if (at >= kw_word[k].len() || kw_word[k][at] != c) begin
                            kw_track = KW_NONE;
                        end else if (at + 1 == kw_word[k].len()) begin
                            note_fresh(make_tok(KIND_KEYWORD,
                                k ? KW_CODE_RETURN : KW_CODE_FUNCTION,
                                ident_line, ident_col, ident_pos,
                                16'(kw_word[k].len())));
                            in_ident  = 1'b0;
                            kw_track  = KW_NONE;
                            ident_len = '0;
                        end
                    end
                    step(c);
                end else begin
                    flush_ident();
                    is_sym = 1'b1;
                    scode  = CODE_NONE;
                    case (c)
                        CH_LBRACE: scode = SYM_LBRACE;
                        CH_RBRACE: scode = SYM_RBRACE;
                        CH_LPAREN: scode = SYM_LPAREN;
                        CH_RPAREN: scode = SYM_RPAREN;
                        CH_SEMI:   scode = SYM_SEMI;
                        CH_PLUS:   scode = SYM_PLUS;
                        default:   is_sym = 1'b0;
                    endcase
                    if (alpha(c)) begin
                        in_ident   = 1'b1;
                        ident_len  = 16'd1;
                        ident_line = line_pos;
                        ident_col  = col_pos;
                        ident_pos  = byte_pos;
                        kw_track   = (c == CH_F) ? KW_FUNCTION :
                                     (c == CH_R) ? KW_RETURN : KW_NONE;
                        step(c);
                    end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
                        step(c);
                    end else if (is_sym) begin
                        note_fresh(make_tok(KIND_SYMBOL, scode, line_pos, col_pos,
                                            byte_pos, 16'd1));
                        step(c);
                    end else begin
                        // unlexable byte: not consumed, lexer stops until end of source
                        note_fresh(make_tok(KIND_ERROR, CODE_NONE, line_pos, col_pos,
                                            byte_pos, 16'd0));
                        stuck = 1'b1;
                    end
                end
            end
            if (eos) begin
                if (!stuck) flush_ident();
                note_fresh(make_tok(KIND_END, CODE_NONE, line_pos, col_pos,
                                    byte_pos, 16'd0));
                clear_state();
            end
            if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i]) due.insert(due.size(), fresh[i]);
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // one accepted token from the dut against the oldest one due
        function void match_token(logic [87:0] d, logic last);
            tok_res_t got;
            tok_res_t want;
            got = {last, d[85:0]};
            if (due.size() == 0) begin
                $error("unexpected token: kind %0d code %0d index %0d",
                       got.kind, got.code, got.index);
                errors++;
                return;
            end
            want = due.pop_front();
            cmp("token_kind", want.kind, got.kind);
            cmp("token_code", want.code, got.code);
            cmp("start_line", want.line, got.line);
            cmp("start_col", want.col, got.col);
            cmp("start_index", want.index, got.index);
            cmp("token_length", want.length, got.length);
            cmp("last_of_run", want.last, got.last);
            cmp("zero pad", 0, d[87:86]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        m_tlast;

    token_ledger ledger;
    int          src_max;
    int          sink_max;
    int          cycles;

    keyword_identifier_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** keyword_identifier_tokenizer: FAILED **");
            $finish;
        end
    end

    // push one source byte, after an idle gap of the given number of cycles
    task automatic send_byte(logic [7:0] c, logic eos, int gap);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eos;
        do @(posedge clk); while (!s_tready);
        ledger.take_byte(c, eos);
    endtask

    task automatic send_text(string s, bit eos_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eos_at_end && (i == s.len() - 1), $urandom_range(0, src_max));
    endtask

    // hold the source until every predicted token has come out
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (ledger.due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // append one byte to a source text
    function automatic void add_char(ref logic [7:0] q[$], input logic [7:0] ch);
        q.insert(q.size(), ch);
    endfunction

    function automatic logic [7:0] rand_tail();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return CH_DOLLAR;
    endfunction

    // one random source text, mostly well formed tokens with occasional noise
    function automatic void build_source(ref logic [7:0] txt[$]);
        int    ntok;
        int    len;
        string kw;
        logic [7:0] sym_set[6];
        logic [7:0] ws_set[3];
        sym_set = '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SEMI, CH_PLUS};
        ws_set  = '{CH_SPACE, CH_TAB, CH_NL};
        txt.delete();
        ntok = $urandom_range(1, 12);
        repeat (ntok) begin
            if ($urandom_range(0, 1))
                kw = "return";
            else
                kw = "function";
            case ($urandom_range(0, 39)) inside
                [0:4]: begin
                    for (int i = 0; i < kw.len(); i++) add_char(txt, kw[i]);
                end
                [5:7]: begin
                    len = $urandom_range(1, kw.len() - 1);
                    for (int i = 0; i < len; i++) add_char(txt, kw[i]);
                end
                [8:17]: begin
                    len = $urandom_range(1, 6);
                    add_char(txt, $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                                       : 8'("A" + $urandom_range(0, 25)));
                    repeat (len - 1) add_char(txt, rand_tail());
                end
                [18:25]: add_char(txt, sym_set[$urandom_range(0, 5)]);
                [26:37]: add_char(txt, ws_set[$urandom_range(0, 2)]);
                default: add_char(txt, 8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // result side: random stall per item, checked at the rising edge
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = $urandom_range(0, sink_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            ledger.match_token(m_tdata, m_tlast);
        end
    end

    // reset and stimulus
    initial
    begin
        logic [7:0] txt[$];
        int         fed;
        int         nsrc;
        ledger   = new();
        src_max  = 11;
        sink_max = 11;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed: a keyword with trailing identifier, all symbols, whitespace kinds
        send_text("functionx( )", 1'b0);
        send_text("\n\tretZ$9{}+;", 1'b1);
        // identifier, non-ascii error and end from one byte
        send_text("ab", 1'b0);
        send_byte(8'hFF, 1'b1, $urandom_range(0, src_max));
        // keyword prefix flushed as identifier at end of source
        send_text("fun", 1'b1);
        // error at token start, then ignored bytes, end marker still comes
        send_text("$", 1'b0);
        send_byte(8'h00, 1'b0, $urandom_range(0, src_max));
        send_text("q", 1'b1);
        send_text("9", 1'b1);
        drain();

        // random sources, idling on and off per source
        fed  = 0;
        nsrc = 0;
        while (fed < RAND_BYTES) begin
            build_source(txt);
            if ($urandom_range(0, 3) == 0) begin
                src_max  = 0;
                sink_max = 0;
            end else begin
                src_max  = 11;
                sink_max = $urandom_range(0, 1) ? 11 : 0;
            end
            foreach (txt[i]) begin
                fed++;
                send_byte(txt[i], i == txt.size() - 1, $urandom_range(0, src_max));
            end
            nsrc++;
            if (nsrc == 10) drain();
        end
        drain();

        if (ledger.errors == 0 && ledger.due.size() == 0)
            $display("** keyword_identifier_tokenizer: PASSED **");
        else
            $display("** keyword_identifier_tokenizer: FAILED **");
        $finish;
    end

endmodule
